FILE: design/dlga_pkg.sv
// ----------------------------------------------------------------------------
// dlga_pkg
// Shared types, codes and arithmetic helpers of the dense-layer gradient
// accumulator.
// ----------------------------------------------------------------------------
package dlga_pkg;

    localparam logic [2:0] CMD_LOAD_W   = 3'd0;
    localparam logic [2:0] CMD_LOAD_X   = 3'd1;
    localparam logic [2:0] CMD_DELTA    = 3'd2;
    localparam logic [2:0] CMD_END_ROW  = 3'd3;
    localparam logic [2:0] CMD_RD_GRAD  = 3'd4;
    localparam logic [2:0] CMD_RD_BIAS  = 3'd5;
    localparam logic [2:0] CMD_CLEAR    = 3'd6;

    localparam logic [1:0] KIND_ERR  = 2'd0;
    localparam logic [1:0] KIND_GRAD = 2'd1;
    localparam logic [1:0] KIND_BIAS = 2'd2;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_EXEC,
        S_BIAS,
        S_MG,
        S_AG,
        S_AE,
        S_ER_OUT,
        S_RD_OUT
    } t_state;

    // Q24.24 product to Q16.16, half rounds towards plus infinity
    function automatic logic signed [39:0] rnd_q16(input logic signed [47:0] p);
        logic signed [47:0] t;
        t = p + 48'sd128;
        return t[47:8];
    endfunction

    // accumulator is {sticky, value[31:0]}; clamp to the signed 32-bit range
    function automatic logic [32:0] sat_add(input logic [32:0] acc,
                                            input logic signed [39:0] add);
        logic signed [41:0] s;
        s = 42'(signed'(acc[31:0])) + 42'(add);
        if (s > 42'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (s < -42'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {acc[32], s[31:0]};
        end
    endfunction

endpackage

FILE: design/dense_layer_gradient_accumulator.sv
// ----------------------------------------------------------------------------
// dense_layer_gradient_accumulator
// Backward pass of a fully connected layer in Q8.8: gradients, bias
// gradients and error row accumulated through one shared multiplier.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s         in   i_s_tvalid/o_s_tready tdata: row,col,data,dy,slope; tuser: command
//  m         out  o_m_tvalid/i_m_tready tdata: index,value,sat; tuser: kind; tlast
//  cfg       in   i_cfg_we              i_cfg_wdata: propagate_error
//
//  Delta item: one 32x16 multiplier used for dy*slope, then twice per input index.
//  End of row: the error row is read out and cleared, waiting on output stalls.
//  After reset and after a clear item a sweep zeroes the gradient memories
//  (and, after reset, the error row); no item is taken.
//  The result register holds while i_m_tready is low; the sequencer waits on it.
module dense_layer_gradient_accumulator
    import dlga_pkg::*;
#(
    parameter int IN_DIM  = 16,
    parameter int OUT_DIM = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [5:0] row_index, [13:6] col_index, [29:14] data_value,
    // [45:30] dy_value, [61:46] slope_value, [63:62] zero
    input  logic [63:0] i_s_tdata,
    // [2:0] command
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [5:0] result_index, [37:6] result_value, [38] saturated, [39] zero
    output logic [39:0] o_m_tdata,
    // [1:0] result_kind
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    localparam int NW = IN_DIM * OUT_DIM;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int IW = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int OW = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;

    logic [15:0] w_mem [NW];
    logic [15:0] x_mem [IN_DIM];
    logic [32:0] g_mem [NW];
    logic [32:0] b_mem [OUT_DIM];
    logic [32:0] e_mem [IN_DIM];

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_addr, n_addr;
    logic r_clr_err, r_prop;
    logic [2:0] r_cmd;
    logic [5:0] r_ri;
    logic [7:0] r_ci;
    logic signed [15:0] r_data, r_dy, r_slope;
    logic signed [31:0] r_delta;
    logic signed [47:0] r_prod;
    logic [15:0] r_w_rd, r_x_rd;
    logic [32:0] r_g_rd, r_b_rd, r_e_rd;
    logic r_ovalid, r_olast, r_osat;
    logic [1:0] r_okind;
    logic [5:0] r_oidx;
    logic [31:0] r_oval;

    logic row_ok, col_ok, ofree;
    logic [AW-1:0] item_addr;
    logic signed [31:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [47:0] mul_p;
    logic ld_delta, ld_prod, ld_out;
    logic [1:0] out_kind;
    logic [5:0] out_idx;
    logic [32:0] out_acc;
    logic out_last;
    logic w_we, x_we, g_we, b_we, e_we;
    logic w_re, x_re, g_re, b_re, e_re;
    logic [AW-1:0] w_a, g_wa, g_ra;
    logic [IW-1:0] x_a, e_wa, e_ra;
    logic [OW-1:0] b_wa, b_ra;
    logic [32:0] g_wd, b_wd, e_wd;

    assign row_ok    = 32'(r_ri) < IN_DIM;
    assign col_ok    = 32'(r_ci) < OUT_DIM;
    assign item_addr = AW'(32'(r_ri) * OUT_DIM + 32'(r_ci));
    assign ofree     = !r_ovalid || i_m_tready;
    assign mul_p     = 48'(mul_a) * 48'(mul_b);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_addr   = r_addr;
        mul_a    = r_delta;
        mul_b    = signed'(r_x_rd);
        ld_delta = 1'b0;
        ld_prod  = 1'b0;
        ld_out   = 1'b0;
        out_kind = KIND_ERR;
        out_idx  = '0;
        out_acc  = '0;
        out_last = 1'b1;
        w_we = 1'b0; x_we = 1'b0; g_we = 1'b0; b_we = 1'b0; e_we = 1'b0;
        w_re = 1'b0; x_re = 1'b0; g_re = 1'b0; b_re = 1'b0; e_re = 1'b0;
        w_a  = item_addr;
        x_a  = r_ri[IW-1:0];
        g_wa = r_addr;
        g_ra = r_addr;
        b_wa = r_ci[OW-1:0];
        b_ra = r_ci[OW-1:0];
        e_wa = r_idx;
        e_ra = r_idx;
        g_wd = '0;
        b_wd = '0;
        e_wd = '0;
        case (r_state)
            S_CLR: begin
                g_we = 1'b1;
                b_we = 32'(r_addr) < OUT_DIM;
                b_wa = r_addr[OW-1:0];
                e_we = r_clr_err && (32'(r_addr) < IN_DIM);
                e_wa = r_addr[IW-1:0];
                n_addr = r_addr + 1'b1;
                if (32'(r_addr) == NW - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_cmd)
                    CMD_LOAD_W: w_we = row_ok && col_ok;
                    CMD_LOAD_X: x_we = row_ok;
                    CMD_DELTA: begin
                        if (col_ok) begin
                            mul_a    = 32'(r_dy);
                            mul_b    = r_slope;
                            ld_delta = 1'b1;
                            b_re     = 1'b1;
                            n_idx    = '0;
                            n_addr   = AW'(r_ci);
                            n_state  = S_BIAS;
                        end
                    end
                    CMD_END_ROW: begin
                        e_re = 1'b1; e_ra = '0;
                        e_we = 1'b1; e_wa = '0;
                        n_idx   = '0;
                        n_state = S_ER_OUT;
                    end
                    CMD_RD_GRAD: begin
                        g_re = 1'b1;
                        g_ra = item_addr;
                        n_state = S_RD_OUT;
                    end
                    CMD_RD_BIAS: begin
                        b_re = 1'b1;
                        n_state = S_RD_OUT;
                    end
                    CMD_CLEAR: begin
                        n_addr  = '0;
                        n_state = S_CLR;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_BIAS: begin
                b_we = 1'b1;
                b_wd = sat_add(r_b_rd, 40'(r_delta));
                // fetch operands of input index 0
                x_re = 1'b1; x_a = r_idx;
                w_re = 1'b1; w_a = r_addr;
                g_re = 1'b1;
                e_re = 1'b1;
                n_state = S_MG;
            end
            S_MG: begin
                ld_prod = 1'b1;
                n_state = S_AG;
            end
            S_AG: begin
                g_we    = 1'b1;
                g_wd    = sat_add(r_g_rd, rnd_q16(r_prod));
                mul_b   = signed'(r_w_rd);
                ld_prod = 1'b1;
                n_state = S_AE;
            end
            S_AE: begin
                e_we = r_prop;
                e_wd = sat_add(r_e_rd, rnd_q16(r_prod));
                if (32'(r_idx) == IN_DIM - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_addr = r_addr + AW'(OUT_DIM);
                    x_re = 1'b1; x_a = n_idx;
                    w_re = 1'b1; w_a = n_addr;
                    g_re = 1'b1; g_ra = n_addr;
                    e_re = 1'b1; e_ra = n_idx;
                    n_state = S_MG;
                end
            end
            S_ER_OUT: begin
                if (ofree) begin
                    ld_out   = 1'b1;
                    out_kind = KIND_ERR;
                    out_idx  = 6'(r_idx);
                    out_acc  = r_e_rd;
                    out_last = 32'(r_idx) == IN_DIM - 1;
                    if (out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // read next element and clear it behind the read
                        n_idx = r_idx + 1'b1;
                        e_re = 1'b1; e_ra = n_idx;
                        e_we = 1'b1; e_wa = n_idx;
                    end
                end
            end
            S_RD_OUT: begin
                if (ofree) begin
                    ld_out = 1'b1;
                    if (r_cmd == CMD_RD_GRAD) begin
                        out_kind = KIND_GRAD;
                        out_acc  = (row_ok && col_ok) ? r_g_rd : '0;
                    end else begin
                        out_kind = KIND_BIAS;
                        out_acc  = col_ok ? r_b_rd : '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_addr    <= '0;
            r_idx     <= '0;
            r_clr_err <= 1'b1;
            r_prop    <= 1'b1;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_idx   <= n_idx;
            if (r_state == S_CLR && n_state == S_IDLE) begin
                r_clr_err <= 1'b0;
            end
            if (i_cfg_we) begin
                r_prop <= i_cfg_wdata;
            end
            if (ld_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_cmd   <= i_s_tuser;
            r_ri    <= i_s_tdata[5:0];
            r_ci    <= i_s_tdata[13:6];
            r_data  <= i_s_tdata[29:14];
            r_dy    <= i_s_tdata[45:30];
            r_slope <= i_s_tdata[61:46];
        end
        if (ld_delta) begin
            r_delta <= mul_p[31:0];
        end
        if (ld_prod) begin
            r_prod <= mul_p;
        end
        if (ld_out) begin
            r_okind <= out_kind;
            r_oidx  <= out_idx;
            r_oval  <= out_acc[31:0];
            r_osat  <= out_acc[32];
            r_olast <= out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            w_mem[w_a] <= r_data;
        end
        if (w_re) begin
            r_w_rd <= w_mem[w_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            x_mem[x_a] <= r_data;
        end
        if (x_re) begin
            r_x_rd <= x_mem[x_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            g_mem[g_wa] <= g_wd;
        end
        if (g_re) begin
            r_g_rd <= g_mem[g_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            b_mem[b_wa] <= b_wd;
        end
        if (b_re) begin
            r_b_rd <= b_mem[b_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            e_mem[e_wa] <= e_wd;
        end
        if (e_re) begin
            r_e_rd <= e_mem[e_ra];
        end
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_osat, r_oval, r_oidx};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !o_s_tready)
        else $error("item taken during clearing sweep");

    a_err_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast && o_m_tuser == KIND_ERR
            |-> 32'(o_m_tdata[5:0]) == IN_DIM - 1)
        else $error("error row ends on wrong index");

    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != KIND_ERR |-> o_m_tlast && o_m_tdata[5:0] == 6'd0)
        else $error("gradient read result malformed");

endmodule
